[src/mlfq_pkg.sv]
// Package for the multilevel feedback queue scheduler.
// Holds level codes, configuration register indexes, reset values and shared structs.
// No dependencies.
package mlfq_pkg;

    localparam int NUM_LEVELS = 3;
    localparam int JOB_ID_W   = 3;
    localparam int BURST_IN_W = 16;
    localparam int QUANTUM_W  = 8;

    typedef logic [1:0] t_level;
    localparam t_level LVL_TOP    = 2'd0;
    localparam t_level LVL_MID    = 2'd1;
    localparam t_level LVL_BOTTOM = 2'd2;

    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CFG_QUANTUM_TOP = 2'd0;
    localparam t_cfg_index CFG_QUANTUM_MID = 2'd1;

    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_READY = 1'b1;

    localparam logic [QUANTUM_W-1:0] QUANTUM_TOP_RST = 8'd6;
    localparam logic [QUANTUM_W-1:0] QUANTUM_MID_RST = 8'd11;

    typedef struct packed {
        logic [QUANTUM_W-1:0] top;
        logic [QUANTUM_W-1:0] mid;
    } t_quanta;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctrl;

    typedef struct packed {
        logic                busy;
        logic [JOB_ID_W-1:0] running_job;
        t_level              running_level;
        logic                done_valid;
        logic [JOB_ID_W-1:0] done_job;
        logic                demoted_valid;
        logic                rejected;
    } t_result;

endpackage

[src/mlfq_queue.sv]
// One level queue of the scheduler: a shift FIFO whose head sits in entry 0.
// Entries carry a job id and its remaining burst. Uses mlfq_pkg.
module mlfq_queue
    import mlfq_pkg::*;
#(
    parameter int DEPTH   = 8,
    parameter int ENTRY_W = 19
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_q_ctrl            i_ctrl,
    input  logic [ENTRY_W-1:0] i_push_data,
    output logic [ENTRY_W-1:0] o_head,
    output logic               o_empty
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;
    logic [CNT_W-1:0]   wr_pos;
    logic               do_push;
    logic [ENTRY_W-1:0] r_data [DEPTH];

    // a push into a full queue is dropped
    assign do_push = i_ctrl.push && (r_cnt != CNT_W'(DEPTH));
    assign wr_pos  = i_ctrl.pop ? (r_cnt - CNT_W'(1)) : r_cnt;
    assign o_head  = r_data[0];
    assign o_empty = (r_cnt == '0);

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !i_ctrl.pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!do_push && i_ctrl.pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // advance entries toward the head on a pop, write the new tail on a push
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (do_push && (wr_pos == CNT_W'(i))) begin
                r_data[i] <= i_push_data;
            end else if (i_ctrl.pop && (i < DEPTH - 1)) begin
                r_data[i] <= r_data[(i + 1) % DEPTH];
            end
        end
    end

endmodule

[src/mlfq_sched.sv]
// Scheduling step: pending flags, running job registers and the three level queues.
// Computes one result per executed item. Uses mlfq_pkg and mlfq_queue.
module mlfq_sched
    import mlfq_pkg::*;
#(
    parameter int MAX_JOBS   = 8,
    parameter int BURST_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_exec,
    input  logic                  i_action,
    input  logic [JOB_ID_W-1:0]   i_job_id,
    input  logic [BURST_IN_W-1:0] i_burst_length,
    input  t_quanta               i_quanta,
    output t_result               o_result
);

    localparam int ID_W    = $clog2(MAX_JOBS);
    localparam int ENTRY_W = ID_W + BURST_BITS;

    logic                  r_run_valid, n_run_valid;
    logic [ID_W-1:0]       r_run_id, n_run_id;
    t_level                r_run_level, n_run_level;
    logic [BURST_BITS-1:0] r_run_burst, n_run_burst;
    logic [QUANTUM_W-1:0]  r_qused, n_qused;
    logic [MAX_JOBS-1:0]   r_pending, n_pending;

    t_q_ctrl            q_ctrl  [NUM_LEVELS];
    logic [ENTRY_W-1:0] q_head  [NUM_LEVELS];
    logic               q_empty [NUM_LEVELS];
    logic [ENTRY_W-1:0] push_data;

    logic                  is_ready;
    logic                  ready_big;
    logic [ID_W-1:0]       ready_id;
    logic [BURST_BITS-1:0] new_burst;
    logic                  rejected;
    logic                  sel_valid;
    t_level                sel_lvl;
    logic                  eff_valid;
    logic [ID_W-1:0]       eff_id;
    t_level                eff_level;
    logic [BURST_BITS-1:0] eff_burst;
    logic [BURST_BITS-1:0] burst_left;
    logic [QUANTUM_W-1:0]  eff_qused;
    logic [QUANTUM_W-1:0]  qused_inc;
    logic [QUANTUM_W-1:0]  quantum;
    logic                  done_v;
    logic                  demote_v;

    for (genvar l = 0; l < NUM_LEVELS; l++) begin : g_queue
        mlfq_queue #(
            .DEPTH   (MAX_JOBS),
            .ENTRY_W (ENTRY_W)
        ) u_queue (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (q_ctrl[l]),
            .i_push_data (push_data),
            .o_head      (q_head[l]),
            .o_empty     (q_empty[l])
        );
    end

    always_comb begin
        is_ready  = (i_action == ACT_READY);
        ready_big = (32'(i_job_id) >= MAX_JOBS);
        ready_id  = ID_W'(i_job_id);
        new_burst = BURST_BITS'(i_burst_length);
        if (new_burst == '0) begin
            new_burst = BURST_BITS'(1);
        end
        rejected = is_ready && (ready_big || r_pending[ready_id]);

        // highest non-empty level wins
        sel_valid = 1'b0;
        sel_lvl   = LVL_TOP;
        for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
            if (!q_empty[l]) begin
                sel_valid = 1'b1;
                sel_lvl   = t_level'(l);
            end
        end

        eff_valid = r_run_valid || sel_valid;
        eff_id    = r_run_valid ? r_run_id : q_head[sel_lvl][ENTRY_W-1:BURST_BITS];
        eff_level = r_run_valid ? r_run_level : sel_lvl;
        eff_burst = r_run_valid ? r_run_burst : q_head[sel_lvl][BURST_BITS-1:0];
        eff_qused = r_run_valid ? r_qused : '0;

        burst_left = eff_burst - BURST_BITS'(1);
        qused_inc  = (eff_qused == '1) ? eff_qused : (eff_qused + QUANTUM_W'(1));
        quantum    = (eff_level == LVL_TOP) ? i_quanta.top : i_quanta.mid;
        if (quantum == '0) begin
            quantum = QUANTUM_W'(1);
        end

        push_data = is_ready ? {ready_id, new_burst} : {eff_id, burst_left};

        n_run_valid = r_run_valid;
        n_run_id    = r_run_id;
        n_run_level = r_run_level;
        n_run_burst = r_run_burst;
        n_qused     = r_qused;
        n_pending   = r_pending;
        done_v      = 1'b0;
        demote_v    = 1'b0;
        for (int l = 0; l < NUM_LEVELS; l++) begin
            q_ctrl[l] = '0;
        end

        if (i_exec) begin
            if (is_ready) begin
                if (!rejected) begin
                    n_pending[ready_id]  = 1'b1;
                    q_ctrl[LVL_TOP].push = 1'b1;
                end
            end else begin
                if (!r_run_valid && sel_valid) begin
                    q_ctrl[sel_lvl].pop = 1'b1;
                end
                if (eff_valid) begin
                    n_run_id    = eff_id;
                    n_run_level = eff_level;
                    n_run_burst = burst_left;
                    if (burst_left == '0) begin
                        done_v            = 1'b1;
                        n_pending[eff_id] = 1'b0;
                        n_run_valid       = 1'b0;
                        n_qused           = '0;
                    end else if ((eff_level != LVL_BOTTOM) && (qused_inc >= quantum)) begin
                        // quantum used up: drop to the next lower level
                        demote_v    = 1'b1;
                        q_ctrl[t_level'(eff_level + 2'd1)].push = 1'b1;
                        n_run_valid = 1'b0;
                        n_qused     = '0;
                    end else begin
                        n_run_valid = 1'b1;
                        n_qused     = qused_inc;
                    end
                end
            end
        end

        o_result.busy          = n_run_valid;
        o_result.running_job   = n_run_valid ? JOB_ID_W'(n_run_id) : '0;
        o_result.running_level = n_run_valid ? n_run_level : LVL_TOP;
        o_result.done_valid    = done_v;
        o_result.done_job      = done_v ? JOB_ID_W'(eff_id) : '0;
        o_result.demoted_valid = demote_v;
        o_result.rejected      = rejected;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_valid <= 1'b0;
            r_run_id    <= '0;
            r_run_level <= LVL_TOP;
            r_run_burst <= '0;
            r_qused     <= '0;
            r_pending   <= '0;
        end else begin
            r_run_valid <= n_run_valid;
            r_run_id    <= n_run_id;
            r_run_level <= n_run_level;
            r_run_burst <= n_run_burst;
            r_qused     <= n_qused;
            r_pending   <= n_pending;
        end
    end

endmodule

[src/mlfq_cpu_scheduler_core.sv]
// Three-level feedback queue processor scheduler, top level.
// Path: an item passes the input register, then the result register, before its result
// is shown. Throughput: one item per cycle unless the result output stalls; the scheduling
// step is a single pass through mlfq_sched.
// Reset (synchronous, active low) empties all queues, clears pending flags and the running
// job, and loads quantum_top = 6 and quantum_mid = 11. Uses mlfq_pkg and mlfq_sched.
module mlfq_cpu_scheduler_core
    import mlfq_pkg::*;
#(
    parameter int MAX_JOBS   = 8,
    parameter int BURST_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item input
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_action,
    input  logic [JOB_ID_W-1:0]   i_job_id,
    input  logic [BURST_IN_W-1:0] i_burst_length,
    // result output
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_busy_res,
    output logic [JOB_ID_W-1:0]   o_running_job,
    output logic [1:0]            o_running_level,
    output logic                  o_done_valid,
    output logic [JOB_ID_W-1:0]   o_done_job,
    output logic                  o_demoted_valid,
    output logic                  o_rejected,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  t_cfg_index            i_cfg_index,
    input  logic [QUANTUM_W-1:0]  i_cfg_data
);

    logic                  r_in_valid;
    logic                  r_in_action;
    logic [JOB_ID_W-1:0]   r_in_job_id;
    logic [BURST_IN_W-1:0] r_in_burst;
    logic                  r_out_valid;
    t_result               r_out;
    t_quanta               r_quanta;

    logic    out_free;
    logic    exec;
    logic    in_xfer;
    t_result step_result;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign exec       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    mlfq_sched #(
        .MAX_JOBS   (MAX_JOBS),
        .BURST_BITS (BURST_BITS)
    ) u_sched (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_exec         (exec),
        .i_action       (r_in_action),
        .i_job_id       (r_in_job_id),
        .i_burst_length (r_in_burst),
        .i_quanta       (r_quanta),
        .o_result       (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_quanta.top <= QUANTUM_TOP_RST;
            r_quanta.mid <= QUANTUM_MID_RST;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (exec) begin
                r_in_valid <= 1'b0;
            end
            if (exec) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_QUANTUM_TOP: r_quanta.top <= i_cfg_data;
                    CFG_QUANTUM_MID: r_quanta.mid <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload registers: hold while stalled
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_action <= i_action;
            r_in_job_id <= i_job_id;
            r_in_burst  <= i_burst_length;
        end
        if (exec) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_busy_res      = r_out.busy;
    assign o_running_job   = r_out.running_job;
    assign o_running_level = r_out.running_level;
    assign o_done_valid    = r_out.done_valid;
    assign o_done_job      = r_out.done_job;
    assign o_demoted_valid = r_out.demoted_valid;
    assign o_rejected      = r_out.rejected;

endmodule
